/* hw/rtl/smpq_pkg.sv */
// ----------------------------------------------------------------------------
// smpq_pkg
// Operation and status codes and the stored entry layout of the stable
// max priority queue.
// ----------------------------------------------------------------------------
package smpq_pkg;

   localparam int PRIO_W    = 16;
   localparam int TAG_W     = 16;
   localparam int ARRIVAL_W = 32;
   localparam int OCC_W     = 7;
   localparam int OP_W      = 2;
   localparam int STATUS_W  = 3;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_SERVE  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_SERVED   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;

   typedef struct packed {
      logic [ARRIVAL_W-1:0] arrival;
      logic [TAG_W-1:0]     tag;
      logic [PRIO_W-1:0]    prio;
   } entry_type;

endpackage

/* hw/rtl/stable_max_priority_queue_unit.sv */
// Insert and clear give their result in the cycle after acceptance.
// A serve does one entry memory read and one compare per held entry, then
// one write-back of the last entry into the freed slot.
// Throughput: one transaction at a time; an empty serve or a full insert
// completes like an insert. Reset clears occupancy and the arrival counter;
// entry memory contents stay undefined until written.
// ----------------------------------------------------------------------------
// stable_max_priority_queue_unit
// Unsorted entry memory scanned by one shared priority/arrival comparator;
// the served slot is refilled from the last entry.
// ----------------------------------------------------------------------------
module stable_max_priority_queue_unit #(
   parameter int DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [15:0] priority_req, [31:16] payload_tag
   input  logic [smpq_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [1:0] operation
   input  logic [smpq_pkg::OP_W-1:0]         req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [15:0] served_tag, [31:16] served_priority, [38:32] occupancy, [39] zero
   output logic [smpq_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // [2:0] status
   output logic [smpq_pkg::STATUS_W-1:0]     rsp_tuser
);
   import smpq_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SCAN = 2'b10
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [ARRIVAL_W-1:0] arrival_ff, arrival_in;
   logic [CNT_W-1:0]   issue_ff, issue_in;
   logic               vld_ff, vld_in;
   logic [IDX_W-1:0]   vidx_ff;
   entry_type          rd_data_ff;
   entry_type          best_ff, best_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [TAG_W-1:0]   rsp_tag_ff, rsp_tag_in;
   logic [PRIO_W-1:0]  rsp_prio_ff, rsp_prio_in;
   logic [CNT_W-1:0]   rsp_occ_ff, rsp_occ_in;

   entry_type          entry_mem [DEPTH];
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   entry_type          mem_wdata;
   logic               rd_en;

   logic               accept;
   logic               take;
   logic               scan_done;
   logic [CNT_W-1:0]   count_dec;
   logic [PRIO_W-1:0]  req_prio;
   logic [TAG_W-1:0]   req_tag;

   function automatic logic goes_first(entry_type a, entry_type b);
      logic [ARRIVAL_W-1:0] diff;
      diff = a.arrival - b.arrival;
      if (a.prio != b.prio) begin
         return a.prio > b.prio;
      end
      return diff[ARRIVAL_W-1];
   endfunction

   assign req_prio  = req_tdata[PRIO_W-1:0];
   assign req_tag   = req_tdata[PRIO_W+TAG_W-1:PRIO_W];
   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept    = req_tvalid && req_tready;
   assign count_dec = count_ff - CNT_W'(1);
   assign rd_en     = (state_ff == S_SCAN) && (issue_ff < count_ff);
   assign take      = (vidx_ff == '0) || goes_first(rd_data_ff, best_ff);
   assign scan_done = vld_ff && (vidx_ff == IDX_W'(count_dec));

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      arrival_in    = arrival_ff;
      issue_in      = issue_ff;
      vld_in        = rd_en;
      best_in       = best_ff;
      best_idx_in   = best_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_occ_in    = rsp_occ_ff;
      mem_we        = 1'b0;
      mem_waddr     = count_ff[IDX_W-1:0];
      mem_wdata     = '{arrival: arrival_ff, tag: req_tag, prio: req_prio};
      if (rd_en) begin
         issue_in = issue_ff + CNT_W'(1);
      end
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_tag_in  = '0;
               rsp_prio_in = '0;
               if (req_tuser == OP_INSERT) begin
                  if (count_ff >= CNT_W'(DEPTH)) begin
                     rsp_status_in = ST_FULL;
                     rsp_occ_in    = count_ff;
                  end else begin
                     mem_we        = 1'b1;
                     count_in      = count_ff + CNT_W'(1);
                     arrival_in    = arrival_ff + ARRIVAL_W'(1);
                     rsp_status_in = ST_INSERTED;
                     rsp_occ_in    = count_ff + CNT_W'(1);
                  end
                  rsp_valid_in = 1'b1;
               end else if (req_tuser == OP_CLEAR) begin
                  count_in      = '0;
                  arrival_in    = '0;
                  rsp_status_in = ST_CLEARED;
                  rsp_occ_in    = '0;
                  rsp_valid_in  = 1'b1;
               end else if (count_ff == '0) begin
                  rsp_status_in = ST_EMPTY;
                  rsp_occ_in    = '0;
                  rsp_valid_in  = 1'b1;
               end else begin
                  issue_in = '0;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (vld_ff && take) begin
               best_in     = rd_data_ff;
               best_idx_in = vidx_ff;
            end
            if (scan_done) begin
               mem_we        = 1'b1;
               mem_waddr     = take ? vidx_ff : best_idx_ff;
               mem_wdata     = rd_data_ff;
               count_in      = count_dec;
               rsp_status_in = ST_SERVED;
               rsp_tag_in    = take ? rd_data_ff.tag : best_ff.tag;
               rsp_prio_in   = take ? rd_data_ff.prio : best_ff.prio;
               rsp_occ_in    = count_dec;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         arrival_ff   <= '0;
         issue_ff     <= '0;
         vld_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         arrival_ff   <= arrival_in;
         issue_ff     <= issue_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      vidx_ff       <= issue_ff[IDX_W-1:0];
      best_ff       <= best_in;
      best_idx_ff   <= best_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_mem[issue_ff[IDX_W-1:0]];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {1'b0, OCC_W'(rsp_occ_ff), rsp_prio_ff, rsp_tag_ff};

endmodule

/* hw/rtl/smpq_checker.sv */
// ----------------------------------------------------------------------------
// smpq_checker
// Port-level checks of the stable max priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module smpq_checker #(
   parameter int DEPTH = 64
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [smpq_pkg::OP_W-1:0]       req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [smpq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [smpq_pkg::STATUS_W-1:0]   rsp_tuser
);
   import smpq_pkg::*;

   // hold a stalled result transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result transaction changed");

   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_SERVED) |-> rsp_tdata[31:0] == 32'd0)
      else $error("non-serve result carries a tag or priority");

   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ((rsp_tuser == ST_CLEARED) || (rsp_tuser == ST_EMPTY))
      |-> rsp_tdata[38:32] == 7'd0)
      else $error("clear or empty serve reports nonzero occupancy");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (DEPTH < 128) |-> 32'(rsp_tdata[38:32]) <= 32'(DEPTH))
      else $error("occupancy above depth");

   // answer a clear in the next cycle
   a_clear_next: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_CLEAR)
      |=> rsp_tvalid && (rsp_tuser == ST_CLEARED))
      else $error("clear transaction not answered in the next cycle");

endmodule

bind stable_max_priority_queue_unit smpq_checker #(.DEPTH(DEPTH)) u_smpq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
